/* design/assert_macros.svh */
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that implies another in the following clock cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/isle_pkg.sv */
package isle_pkg;

  // Default list capacity in elements.
  localparam int CAPACITY_DEF = 1024;

  // Field widths of one transaction.
  localparam int CMD_W    = 3;
  localparam int POS_W    = 11;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 11;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 3'd0,
    CMD_REMOVE    = 3'd1,
    CMD_GET       = 3'd2,
    CMD_PUSH_HEAD = 3'd3,
    CMD_PUSH_TAIL = 3'd4,
    CMD_POP_HEAD  = 3'd5,
    CMD_POP_TAIL  = 3'd6,
    CMD_CLEAR     = 3'd7
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAN,
    ST_READ,
    ST_CAPT,
    ST_MOVE,
    ST_PUT,
    ST_COMMIT,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic plan;
    logic rd_tgt;
    logic capture;
    logic move;
    logic put;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ok;
    logic need_read;
    logic is_ins;
    logic move_done;
  } dp_stat_t;

endpackage

/* design/isle_ram.sv */
module isle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/isle_ctrl.sv */
module isle_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  isle_pkg::dp_stat_t  stat,
  output isle_pkg::dp_cmd_t   cmd
);
  import isle_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_PLAN;
      ST_PLAN: begin
        if (!stat.ok) begin
          state_next = ST_COMMIT;
        end else if (stat.need_read) begin
          state_next = ST_READ;
        end else if (stat.is_ins) begin
          state_next = ST_MOVE;
        end else begin
          state_next = ST_COMMIT;
        end
      end
      ST_READ:   state_next = ST_CAPT;
      ST_CAPT:   state_next = ST_MOVE;
      ST_MOVE: begin
        if (stat.move_done) begin
          state_next = stat.is_ins ? ST_PUT : ST_COMMIT;
        end
      end
      ST_PUT:    state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_RESP;
      ST_RESP:   if (m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd         = '0;
    s_tready    = 1'b0;
    m_tvalid    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_PLAN:   cmd.plan = 1'b1;
      ST_READ:   cmd.rd_tgt = 1'b1;
      ST_CAPT:   cmd.capture = 1'b1;
      ST_MOVE:   cmd.move = 1'b1;
      ST_PUT:    cmd.put = 1'b1;
      ST_COMMIT: cmd.commit = 1'b1;
      ST_RESP:   m_tvalid = 1'b1;
      default:   cmd = '0;
    endcase
  end

endmodule

/* design/isle_datapath.sv */
module isle_datapath #(
  parameter int CAPACITY = isle_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [isle_pkg::IN_W-1:0]  s_tdata,
  output logic [isle_pkg::OUT_W-1:0] m_tdata,
  output logic [$clog2(CAPACITY+1)-1:0] count,
  input  isle_pkg::dp_cmd_t          cmd,
  output isle_pkg::dp_stat_t         stat
);
  import isle_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  // Modular address helpers on the circular store.
  function automatic logic [AW-1:0] a_inc(input logic [AW-1:0] a);
    return (a == AW'(CAPACITY - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] a_dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(CAPACITY - 1) : a - 1'b1;
  endfunction

  function automatic logic [AW-1:0] a_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return AW'(s);
  endfunction

  // Latched transaction and list state.
  cmd_t          cmd_q;
  logic [PW-1:0] pos_q;
  logic [VAL_W-1:0] val_q;
  logic [AW-1:0] head;
  logic [AW-1:0] src;
  logic [AW-1:0] tgt;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] rem;
  logic          step_up;
  logic          front;
  logic          wr_pend;
  logic [VAL_W-1:0] res_value;
  status_t       res_status;

  logic [VAL_W-1:0] rd_data;

  // Decode of the latched command.
  logic is_ins, is_rm, is_get;
  assign is_ins = (cmd_q == CMD_INSERT) || (cmd_q == CMD_PUSH_HEAD) ||
                  (cmd_q == CMD_PUSH_TAIL);
  assign is_rm  = (cmd_q == CMD_REMOVE) || (cmd_q == CMD_POP_HEAD) ||
                  (cmd_q == CMD_POP_TAIL);
  assign is_get = (cmd_q == CMD_GET);

  // Plan: status, effective position and the element move run.
  status_t       p_status;
  logic [CW-1:0] ep;
  logic [CW:0]   ep2;
  logic          p_front;
  logic [CW-1:0] p_rem;
  logic [AW-1:0] p_src;
  logic [AW-1:0] p_tgt;
  logic          p_up;
  logic          full;

  assign full = (count == CW'(CAPACITY));

  always_comb begin
    p_status = STAT_OK;
    case (cmd_q)
      CMD_INSERT: begin
        if (pos_q > PW'(count)) p_status = STAT_RANGE;
        else if (full)          p_status = STAT_FULL;
      end
      CMD_PUSH_HEAD, CMD_PUSH_TAIL: if (full) p_status = STAT_FULL;
      CMD_REMOVE, CMD_GET: if (pos_q >= PW'(count)) p_status = STAT_RANGE;
      CMD_POP_HEAD, CMD_POP_TAIL: if (count == '0) p_status = STAT_EMPTY;
      default: p_status = STAT_OK;
    endcase

    case (cmd_q)
      CMD_PUSH_HEAD, CMD_POP_HEAD: ep = '0;
      CMD_PUSH_TAIL:               ep = count;
      CMD_POP_TAIL:                ep = count - 1'b1;
      default:                     ep = CW'(pos_q);
    endcase
    ep2 = {ep, 1'b0};

    p_tgt   = a_add(head, ep);
    p_front = 1'b0;
    p_rem   = '0;
    p_src   = head;
    p_up    = 1'b1;
    if (is_ins) begin
      p_front = (ep2 <= {1'b0, count});
      if (p_front) begin
        // Shift the leading elements one place towards the front.
        p_rem = ep;
        p_src = head;
        p_up  = 1'b1;
        p_tgt = a_add(a_dec(head), ep);
      end else begin
        // Shift the trailing elements one place towards the back.
        p_rem = count - ep;
        p_src = a_add(head, count - 1'b1);
        p_up  = 1'b0;
      end
    end else if (is_rm) begin
      p_front = (ep2 < {1'b0, count});
      if (p_front) begin
        p_rem = ep;
        p_src = a_dec(p_tgt);
        p_up  = 1'b0;
      end else begin
        p_rem = count - 1'b1 - ep;
        p_src = a_inc(p_tgt);
        p_up  = 1'b1;
      end
    end
  end

  // Element store.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;

  assign ram_we    = (cmd.move && wr_pend) || cmd.put;
  assign ram_waddr = cmd.put ? tgt : wr_addr;
  assign ram_wdata = cmd.put ? val_q : rd_data;
  assign ram_raddr = cmd.rd_tgt ? tgt : src;

  isle_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // List state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      wr_pend <= 1'b0;
    end else begin
      if (cmd.plan) begin
        wr_pend <= 1'b0;
      end else if (cmd.move) begin
        wr_pend <= (rem != '0);
      end
      if (cmd.commit && res_status == STAT_OK) begin
        if (cmd_q == CMD_CLEAR) begin
          count <= '0;
        end else if (is_ins) begin
          count <= count + 1'b1;
          if (front) head <= a_dec(head);
        end else if (is_rm) begin
          count <= count - 1'b1;
          if (front) head <= a_inc(head);
        end
      end
    end
  end

  // Transaction payload and move sequencing.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= cmd_t'(s_tdata[CMD_W-1:0]);
      pos_q <= PW'(s_tdata[CMD_W +: POS_W]);
      val_q <= s_tdata[CMD_W+POS_W +: VAL_W];
    end
    if (cmd.plan) begin
      res_status <= p_status;
      res_value  <= (is_ins && p_status == STAT_OK) ? val_q : '0;
      front      <= p_front;
      rem        <= p_rem;
      src        <= p_src;
      tgt        <= p_tgt;
      step_up    <= p_up;
    end
    if (cmd.capture) begin
      res_value <= rd_data;
    end
    if (cmd.move && rem != '0) begin
      wr_addr <= step_up ? a_dec(src) : a_inc(src);
      src     <= step_up ? a_inc(src) : a_dec(src);
      rem     <= rem - 1'b1;
    end
  end

  assign stat.ok        = (p_status == STAT_OK);
  assign stat.need_read = is_rm || is_get;
  assign stat.is_ins    = is_ins;
  assign stat.move_done = (rem == '0) && !wr_pend;

  assign m_tdata = {3'b000, COUNT_W'(count), res_status, res_value};

endmodule

/* design/indexed_sequence_list_engine_top.sv */
// Ordered list of up to CAPACITY signed 32-bit values, held as a circular
// buffer in one memory with a head pointer. Each accepted transaction gives
// exactly one result transaction. After acceptance the controller steps
// through plan and commit for clear and any refused command, through plan,
// move, put and commit for an insert or a push at either end, and through
// plan, read, capture, move and commit for get, remove and pop; then it
// offers the result. Insert and remove at an index move the elements on the
// nearer side of the index by one place, one element a cycle in the move
// state through the memory's read and write ports; the number moved is
// min(index, count - index) or one less and at most about CAPACITY/2. One
// command is worked on at a time; the result is held until taken and the
// next command is accepted in the cycle after. No clearing pass follows reset.
`include "assert_macros.svh"

module indexed_sequence_list_engine_top #(
  parameter int CAPACITY = isle_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // cmd[2:0], position[13:3], item_value[45:14], zero fill
  input  logic [isle_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // result_value[31:0], status[33:32], count[44:34], zero fill
  output logic [isle_pkg::OUT_W-1:0] m_tdata
);
  import isle_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [$clog2(CAPACITY+1)-1:0] count;

  isle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  isle_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata),
    .count   (count),
    .cmd     (cmd),
    .stat    (stat)
  );

  // The list never holds more than its capacity.
  `ASSERT_ALWAYS(a_count_cap, clk, rst, count <= ($clog2(CAPACITY+1))'(CAPACITY), "count above capacity")
  // A new transaction is never taken while a result waits.
  `ASSERT_ALWAYS(a_one_at_a_time, clk, rst, !(m_tvalid && s_tready), "input taken while result pending")
  // A result is never offered in the cycle after acceptance.
  `ASSERT_NEXT(a_no_early_result, clk, rst, s_tvalid && s_tready, !m_tvalid, "result too early")

endmodule

/* bench/indexed_sequence_list_engine_top_test.sv */
module indexed_sequence_list_engine_top_test;
  import isle_pkg::*;

  localparam int CAP = 1024;
  localparam longint CYCLE_LIMIT = 4000000;

  // Scoreboard: keeps its own copy of the list and the results still owed.
  class list_scoreboard;
    logic [VAL_W-1:0]   elems[$];
    logic [OUT_W-1:0]   owed[$];
    int                 errors;
    int                 checked;

    function void note_command(logic [IN_W-1:0] word);
      cmd_t               op;
      logic [POS_W-1:0]   pos;
      logic [VAL_W-1:0]   val;
      logic [VAL_W-1:0]   res;
      status_t            st;
      int                 n;
      op  = cmd_t'(word[2:0]);
      pos = word[13:3];
      val = word[45:14];
      res = '0;
      st  = STAT_OK;
      n   = elems.size();
      case (op)
        CMD_INSERT, CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
          if (op == CMD_PUSH_HEAD) pos = '0;
          if (op == CMD_PUSH_TAIL) pos = POS_W'(n);
          if (pos > n) st = STAT_RANGE;
          else if (n >= CAP) st = STAT_FULL;
          else begin
            elems.insert(pos, val);
            res = val;
          end
        end
        CMD_REMOVE, CMD_GET: begin
          if (pos >= n) st = STAT_RANGE;
          else begin
            res = elems[pos];
            if (op == CMD_REMOVE) elems.delete(pos);
          end
        end
        CMD_POP_HEAD: begin
          if (n == 0) st = STAT_EMPTY;
          else begin
            res = elems[0];
            elems.delete(0);
          end
        end
        CMD_POP_TAIL: begin
          if (n == 0) st = STAT_EMPTY;
          else begin
            res = elems[n-1];
            elems.delete(n-1);
          end
        end
        default: elems.delete();
      endcase
      owed.insert(owed.size(), {3'b0, COUNT_W'(elems.size()), st, res});
    endfunction

    function void check_result(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] exp;
      if (owed.size() == 0) begin
        $display("%0t: result with none owed: %h", $time, got);
        errors++;
        return;
      end
      exp = owed[0];
      owed.delete(0);
      checked++;
      if (got[31:0] !== exp[31:0]) begin
        $display("%0t: value expected %h actual %h", $time, exp[31:0], got[31:0]);
        errors++;
      end
      if (got[33:32] !== exp[33:32]) begin
        $display("%0t: status expected %0d actual %0d", $time, exp[33:32], got[33:32]);
        errors++;
      end
      if (got[44:34] !== exp[44:34]) begin
        $display("%0t: count expected %0d actual %0d", $time, exp[44:34], got[44:34]);
        errors++;
      end
      if (got[47:45] !== exp[47:45]) begin
        $display("%0t: fill expected %h actual %h", $time, exp[47:45], got[47:45]);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  list_scoreboard sb = new();
  int     send_idle_pct = 17;
  int     recv_idle_pct = 57;
  bit     hold_off = 1'b0;
  longint cycles = 0;
  int     sent = 0;

  indexed_sequence_list_engine_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Note every accepted command and check every accepted result.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_command(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Receiver readiness: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst || hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one command, with random gaps, and wait until it is taken. The
  // valid stays high after acceptance until the next gap or a drain, so
  // that back-to-back commands assign it only once per edge.
  task automatic send(cmd_t op, int pos, logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b0, val, POS_W'(pos), op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // Mostly positions from zero to the current length, sometimes anything.
  function automatic int pick_pos();
    int n;
    n = sb.elems.size();
    case ($urandom_range(9))
      0: return $urandom_range(2047);
      1: return n;
      2: return n + 1;
      default: return (n == 0) ? 0 : $urandom_range(n);
    endcase
  endfunction

  task automatic random_commands(int num, int grow_bias);
    cmd_t op;
    for (int i = 0; i < num; i++) begin
      case ($urandom_range(99) < grow_bias ? $urandom_range(2) : $urandom_range(8))
        0: op = CMD_INSERT;
        1: op = CMD_PUSH_TAIL;
        2: op = CMD_PUSH_HEAD;
        3: op = CMD_REMOVE;
        4: op = CMD_GET;
        5: op = CMD_POP_HEAD;
        6: op = CMD_POP_TAIL;
        7: op = CMD_GET;
        default: op = ($urandom_range(19) == 0) ? CMD_CLEAR : CMD_REMOVE;
      endcase
      send(op, pick_pos(), $urandom());
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list cases, extremes of values and positions.
    send(CMD_POP_HEAD, 0, '0);
    send(CMD_POP_TAIL, 0, '0);
    send(CMD_GET, 0, '0);
    send(CMD_REMOVE, 2047, '0);
    send(CMD_INSERT, 1, 32'h1234_5678);
    send(CMD_INSERT, 0, 32'h8000_0000);
    send(CMD_PUSH_TAIL, 2047, 32'h7FFF_FFFF);
    send(CMD_PUSH_HEAD, 0, 32'hFFFF_FFFF);
    send(CMD_INSERT, 3, 32'h5555_AAAA);
    send(CMD_INSERT, 1, 32'hAAAA_5555);
    send(CMD_GET, 4, '0);
    send(CMD_GET, 5, '0);
    send(CMD_REMOVE, 2, '0);
    send(CMD_REMOVE, 4, '0);
    send(CMD_POP_HEAD, 0, '0);
    send(CMD_POP_TAIL, 0, '0);
    send(CMD_CLEAR, 2047, 32'hFFFF_FFFF);
    send(CMD_GET, 0, '0);

    // Phase one with the first idling pattern.
    random_commands(100, 60);
    drain();

    // Fill to capacity, try the full cases, then empty it again.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (sb.elems.size() < CAP) send(CMD_PUSH_TAIL, 0, $urandom());
    send(CMD_PUSH_HEAD, 0, 32'h1);
    send(CMD_INSERT, CAP, 32'h2);
    send(CMD_INSERT, CAP / 2, 32'h3);
    send(CMD_INSERT, CAP + 1, 32'h4);
    send(CMD_REMOVE, CAP / 2, '0);
    send(CMD_INSERT, CAP / 2, 32'h5);
    send(CMD_GET, CAP - 1, '0);
    send(CMD_CLEAR, 0, '0);

    // Long receiver hold-off while commands keep coming.
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      random_commands(20, 80);
    join
    drain();

    // Phase two with the roles swapped.
    send_idle_pct = 57;
    recv_idle_pct = 17;
    random_commands(100, 25);
    drain();

    // Phase three without idling.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_commands(100, 25);
    drain();

    $display("Sent %0d commands including a fill to %0d elements; %0d results checked.",
             sent, CAP, sb.checked);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
